// ===== hdl/gn3d_pkg.sv =====
// ----------------------------------------------------------------------------
// gn3d_pkg
// Shared codes, constants and types of the 3D gradient noise evaluator.
// ----------------------------------------------------------------------------
package gn3d_pkg;

  // item kinds carried on the input tuser
  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_EVAL    = 2'd1;
  localparam logic [1:0] OP_ADVANCE = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_GRID_SIDE = 2'd0;
  localparam logic [1:0] CFG_SCALE_X   = 2'd1;
  localparam logic [1:0] CFG_SCALE_Y   = 2'd2;

  localparam int unsigned CfgW  = 24;
  localparam int unsigned ValW  = 40;   // working width of dots and blends
  localparam int unsigned ProdW = 58;   // ValW x 18 product

  localparam logic signed [ValW-1:0] Q16One     = 40'sd65536;
  localparam logic signed [ValW-1:0] FadeOff15  = 40'sd983040;
  localparam logic signed [ValW-1:0] FadeOff10  = 40'sd655360;
  localparam logic signed [17:0]     DispOne    = 18'sd65536;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POS,
    ST_FADE,
    ST_READ,
    ST_DOT,
    ST_BLEND,
    ST_DONE
  } state_e;

endpackage

// ===== hdl/gradient_noise_3d_eval.sv =====
// ----------------------------------------------------------------------------
// gradient_noise_3d_eval
// Gradient noise evaluator over a two-layer grid of stored 3D gradients.
// ----------------------------------------------------------------------------
// Write and advance items finish in the cycle they are accepted and return a
// zero result at once. An evaluate item holds the block throughout: the
// position multiply as it is accepted, the grid check, 8 steps for the two
// fade curves, for each of the 8 corner dot products one gradient store read
// and three products through the single shared multiplier, 7 blends and a
// last step to scale and clamp; a sample whose corner falls outside the grid
// returns from the grid check. The shared 40x18 multiplier serves the fade,
// dot and blend steps. The gradient store needs no clearing after reset.
module gradient_noise_3d_eval #(
  parameter int unsigned GRID_SIDE      = 32,
  parameter int unsigned GRAD_FRAC_BITS = 14
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [23:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // entry_index[10:0], grad_x[26:11], grad_y[42:27], grad_z[58:43],
  // coord_x[82:59], coord_y[106:83], z_frac[122:107], zero fill above
  input  logic [127:0] s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // noise_value[15:0], out_of_range[16], zero fill above
  output logic [23:0]  m_axis_tdata
);

  localparam int unsigned CellSlots = GRID_SIDE * GRID_SIDE;
  localparam int unsigned CW = $clog2(CellSlots);
  localparam int unsigned AW = CW + 1;
  localparam int unsigned EW = (AW > 13) ? AW + 1 : 14;
  localparam int unsigned Depth = 2 * CellSlots;
  localparam logic [EW-1:0] SlotsE = EW'(CellSlots);
  localparam int unsigned VW = gn3d_pkg::ValW;

  // payload fields
  logic [10:0] in_entry;
  logic [15:0] in_gx, in_gy, in_gz, in_zf;
  logic [23:0] in_cx, in_cy;
  assign in_entry = s_axis_tdata[10:0];
  assign in_gx    = s_axis_tdata[26:11];
  assign in_gy    = s_axis_tdata[42:27];
  assign in_gz    = s_axis_tdata[58:43];
  assign in_cx    = s_axis_tdata[82:59];
  assign in_cy    = s_axis_tdata[106:83];
  assign in_zf    = s_axis_tdata[122:107];

  gn3d_pkg::state_e state_q, state_d;

  logic [5:0]  gsu_q;
  logic [23:0] scx_q, scy_q;
  logic        ptr_q;

  logic [47:0] px_q, py_q;
  logic [15:0] zf_q, xf_q, yf_q;
  logic [12:0] c00_q;
  logic [2:0]  step_q, corner_q, blend_q;
  logic [1:0]  term_q;
  logic signed [VW-1:0] fb_q, acc_q;
  logic signed [17:0]   sx_q, sy_q;
  logic signed [VW-1:0] dot_q [8];

  logic        out_valid_q;
  logic [15:0] out_noise_q;
  logic        out_oor_q;

  logic [47:0] mem [Depth];
  logic [47:0] rdata_q;

  // handshake and control
  logic accept, out_free, load_out, oor, mem_we, mem_re;
  logic [15:0] load_noise;
  logic        load_oor;

  assign out_free = !out_valid_q || m_axis_tready;
  assign accept   = s_axis_tvalid && s_axis_tready;

  // grid check
  logic [23:0] xi, yi;
  logic [24:0] xi1, yi1;
  logic [12:0] far_c;
  assign xi    = px_q[47:24];
  assign yi    = py_q[47:24];
  assign xi1   = {1'b0, xi} + 25'd1;
  assign yi1   = {1'b0, yi} + 25'd1;
  assign far_c = 13'(xi[5:0]) + 13'd1 + 13'(gsu_q) * (13'(yi[5:0]) + 13'd1);
  assign oor   = (xi1 >= 25'(gsu_q)) || (yi1 >= 25'(gsu_q)) ||
                 (EW'(far_c) >= SlotsE);

  // write and read addresses
  logic [EW-1:0] wcell, rcell, waddr_e, raddr_e;
  logic          wlayer, rlayer;
  assign wcell   = EW'(in_entry[9:0]);
  assign wlayer  = in_entry[10] ^ ptr_q;
  assign waddr_e = wlayer ? wcell + SlotsE : wcell;
  assign rcell   = EW'(c00_q) + EW'(corner_q[0]) + (corner_q[1] ? EW'(gsu_q) : '0);
  assign rlayer  = corner_q[2] ^ ptr_q;
  assign raddr_e = rlayer ? rcell + SlotsE : rcell;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gn3d_pkg::ST_IDLE: begin
        if (accept && s_axis_tuser == gn3d_pkg::OP_EVAL) state_d = gn3d_pkg::ST_POS;
      end
      gn3d_pkg::ST_POS:   state_d = oor ? gn3d_pkg::ST_IDLE : gn3d_pkg::ST_FADE;
      gn3d_pkg::ST_FADE: begin
        if (step_q == 3'd7) state_d = gn3d_pkg::ST_READ;
      end
      gn3d_pkg::ST_READ:  state_d = gn3d_pkg::ST_DOT;
      gn3d_pkg::ST_DOT: begin
        if (term_q == 2'd2) begin
          state_d = (corner_q == 3'd7) ? gn3d_pkg::ST_BLEND : gn3d_pkg::ST_READ;
        end
      end
      gn3d_pkg::ST_BLEND: begin
        if (blend_q == 3'd6) state_d = gn3d_pkg::ST_DONE;
      end
      gn3d_pkg::ST_DONE:  state_d = gn3d_pkg::ST_IDLE;
      default:            state_d = gn3d_pkg::ST_IDLE;
    endcase
  end

  // final scale and clamp of the blended value
  logic signed [VW-1:0] fin;
  assign fin = (dot_q[0] + gn3d_pkg::Q16One) >>> 1;

  // control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    load_out      = 1'b0;
    load_noise    = '0;
    load_oor      = 1'b0;
    unique case (state_q)
      gn3d_pkg::ST_IDLE: begin
        s_axis_tready = out_free;
        if (accept && s_axis_tuser != gn3d_pkg::OP_EVAL) load_out = 1'b1;
        mem_we = accept && s_axis_tuser == gn3d_pkg::OP_WRITE && wcell < SlotsE;
      end
      gn3d_pkg::ST_POS: begin
        if (oor) begin
          load_out = 1'b1;
          load_oor = 1'b1;
        end
      end
      gn3d_pkg::ST_READ: mem_re = 1'b1;
      gn3d_pkg::ST_DONE: begin
        load_out = 1'b1;
        if (fin < 0)                        load_noise = '0;
        else if (fin > 40'sd65535)          load_noise = 16'hFFFF;
        else                                load_noise = fin[15:0];
      end
      default: ;
    endcase
  end

  // shared multiplier operands
  logic signed [VW-1:0] t40, fa, mul_a, bl_a, bl_b;
  logic signed [17:0]   mul_b, bl_t, dx, dy, dz;
  logic [15:0]          ft;
  logic signed [gn3d_pkg::ProdW-1:0] prod;
  logic signed [VW-1:0] prod_sh, dsum;
  logic [2:0]           bl_dst;

  assign ft  = step_q[2] ? yf_q : xf_q;
  assign t40 = $signed({24'd0, ft});
  assign fa  = (t40 <<< 2) + (t40 <<< 1) - gn3d_pkg::FadeOff15;
  assign dx  = corner_q[0] ? $signed({2'b0, xf_q}) - gn3d_pkg::DispOne : $signed({2'b0, xf_q});
  assign dy  = corner_q[1] ? $signed({2'b0, yf_q}) - gn3d_pkg::DispOne : $signed({2'b0, yf_q});
  assign dz  = corner_q[2] ? $signed({2'b0, zf_q}) - gn3d_pkg::DispOne : $signed({2'b0, zf_q});

  always_comb begin
    bl_a = dot_q[0];
    bl_b = dot_q[1];
    bl_t = sx_q;
    bl_dst = 3'd0;
    case (blend_q)
      3'd0: begin bl_a = dot_q[0]; bl_b = dot_q[1]; bl_t = sx_q; bl_dst = 3'd0; end
      3'd1: begin bl_a = dot_q[2]; bl_b = dot_q[3]; bl_t = sx_q; bl_dst = 3'd2; end
      3'd2: begin bl_a = dot_q[4]; bl_b = dot_q[5]; bl_t = sx_q; bl_dst = 3'd4; end
      3'd3: begin bl_a = dot_q[6]; bl_b = dot_q[7]; bl_t = sx_q; bl_dst = 3'd6; end
      3'd4: begin bl_a = dot_q[0]; bl_b = dot_q[2]; bl_t = sy_q; bl_dst = 3'd0; end
      3'd5: begin bl_a = dot_q[4]; bl_b = dot_q[6]; bl_t = sy_q; bl_dst = 3'd4; end
      default: begin
        bl_a = dot_q[0]; bl_b = dot_q[4]; bl_t = $signed({2'b0, zf_q}); bl_dst = 3'd0;
      end
    endcase
  end

  always_comb begin
    mul_a = bl_b - bl_a;
    mul_b = bl_t;
    case (state_q)
      gn3d_pkg::ST_FADE: begin
        mul_a = (step_q[1:0] == 2'd0) ? fa : fb_q;
        mul_b = $signed({2'b0, ft});
      end
      gn3d_pkg::ST_DOT: begin
        case (term_q)
          2'd0:    begin mul_a = VW'($signed(rdata_q[15:0]));  mul_b = dx; end
          2'd1:    begin mul_a = VW'($signed(rdata_q[31:16])); mul_b = dy; end
          default: begin mul_a = VW'($signed(rdata_q[47:32])); mul_b = dz; end
        endcase
      end
      default: ;
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign prod_sh = VW'(prod >>> 16);
  assign dsum    = acc_q + VW'(prod);

  // gradient store
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr_e[AW-1:0]] <= {in_gz, in_gy, in_gx};
    if (mem_re) rdata_q <= mem[raddr_e[AW-1:0]];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gn3d_pkg::ST_IDLE;
      gsu_q       <= 6'd32;
      scx_q       <= 24'd65536;
      scy_q       <= 24'd65536;
      ptr_q       <= 1'b0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      corner_q    <= '0;
      term_q      <= '0;
      blend_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          gn3d_pkg::CFG_GRID_SIDE: gsu_q <= cfg_data_i[5:0];
          gn3d_pkg::CFG_SCALE_X:   scx_q <= cfg_data_i;
          gn3d_pkg::CFG_SCALE_Y:   scy_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept && s_axis_tuser == gn3d_pkg::OP_ADVANCE) ptr_q <= ~ptr_q;
      if (load_out)                          out_valid_q <= 1'b1;
      else if (m_axis_tready)                out_valid_q <= 1'b0;
      case (state_q)
        gn3d_pkg::ST_POS: begin
          step_q   <= '0;
          corner_q <= '0;
          term_q   <= '0;
          blend_q  <= '0;
        end
        gn3d_pkg::ST_FADE:  step_q <= step_q + 3'd1;
        gn3d_pkg::ST_DOT: begin
          if (term_q == 2'd2) begin
            term_q   <= '0;
            corner_q <= corner_q + 3'd1;
          end else begin
            term_q <= term_q + 2'd1;
          end
        end
        gn3d_pkg::ST_BLEND: blend_q <= blend_q + 3'd1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept && s_axis_tuser == gn3d_pkg::OP_EVAL) begin
      px_q <= in_cx * scx_q;
      py_q <= in_cy * scy_q;
      zf_q <= in_zf;
    end
    if (load_out) begin
      out_noise_q <= load_noise;
      out_oor_q   <= load_oor;
    end
    case (state_q)
      gn3d_pkg::ST_POS: begin
        xf_q  <= px_q[23:8];
        yf_q  <= py_q[23:8];
        c00_q <= 13'(xi[5:0]) + 13'(gsu_q) * 13'(yi[5:0]);
      end
      gn3d_pkg::ST_FADE: begin
        if (step_q[1:0] == 2'd0) fb_q <= prod_sh + gn3d_pkg::FadeOff10;
        else                     fb_q <= prod_sh;
        if (step_q == 3'd3) sx_q <= 18'(prod_sh);
        if (step_q == 3'd7) sy_q <= 18'(prod_sh);
      end
      gn3d_pkg::ST_DOT: begin
        if (term_q == 2'd0) acc_q <= VW'(prod);
        else                acc_q <= dsum;
        if (term_q == 2'd2) dot_q[corner_q] <= dsum >>> GRAD_FRAC_BITS;
      end
      gn3d_pkg::ST_BLEND: dot_q[bl_dst] <= bl_a + prod_sh;
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_oor_q, out_noise_q};

endmodule
